@@ rtl/gram_schmidt_orthogonalizer_macros.svh @@
// Assertion macros for the Gram-Schmidt orthogonaliser checker
`ifndef GRAM_SCHMIDT_ORTHOGONALIZER_MACROS_SVH
`define GRAM_SCHMIDT_ORTHOGONALIZER_MACROS_SVH
// implication checked every cycle outside reset
`define GSO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define GSO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/gso_pkg.sv @@
// Package: constants, types and helpers of the Gram-Schmidt orthogonaliser
`default_nettype none
package gso_pkg;
  localparam int MaxVectors = 8;
  localparam int MaxLength = 8;
  localparam int VW = $clog2(MaxVectors);
  localparam int EW = $clog2(MaxLength);
  localparam int AW = VW + EW;

  localparam logic CfgNumVectors = 1'b0;
  localparam logic CfgVectorLength = 1'b1;

  localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR,   // clear accumulator
    OP_DOT,   // acc += a*b
    OP_DIV,   // coefficient = acc / norm (multi-cycle)
    OP_UPD,   // cur -= c*base, acc += h*h
    OP_NORM   // store acc as norm of vector
  } op_t;

  typedef struct packed {
    op_t          op;
    logic [VW-1:0] va;   // current vector
    logic [VW-1:0] vb;   // base vector
    logic [EW-1:0] el;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic acc_zero;
    logic busy;
  } sts_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return S64Max;
    if (a[63] && b[63] && !s[63]) return S64Min;
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [3:0] clamp_reg(logic [3:0] v, logic [3:0] mx);
    if (v == 4'd0) return 4'd1;
    if (v > mx) return mx;
    return v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/gso_stream_if.sv @@
// Valid/ready stream interfaces for the orthogonaliser
`default_nettype none
interface gso_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface gso_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [2:0]  vector_number;
  logic [2:0]  element_number;
  logic        dependent_error;
  logic        last;
  modport source (output valid, output result_value, output vector_number,
                  output element_number, output dependent_error, output last,
                  input ready);
  modport sink (input valid, input result_value, input vector_number,
                input element_number, input dependent_error, input last,
                output ready);
endinterface
`default_nettype wire

@@ rtl/gso_datapath.sv @@
// Datapath: vector memory, multiplier, accumulator, serial divider, norms
`default_nettype none
module gso_datapath import gso_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic signed [31:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic signed [31:0]     rd_data,
  output sts_t                   sts
);
  logic signed [31:0] mem [MaxVectors*MaxLength];
  logic signed [63:0] norms [MaxVectors];
  logic signed [63:0] acc;
  logic signed [31:0] coef;

  // operand fetch stage
  logic signed [31:0] cur_q, base_q;
  logic [2:0]         op_q;
  logic [AW-1:0]      cur_addr_q;
  // product stage
  logic signed [63:0] prod;
  logic [2:0]         op_p;
  logic [AW-1:0]      cur_addr_p;
  logic signed [31:0] cur_p;
  // update stage
  logic signed [31:0] h;
  logic               h_vld;
  logic [AW-1:0]      h_addr;

  logic [AW-1:0] a_addr, b_addr;
  // the output read shares the current-vector port while no operation runs
  assign a_addr = (cmd.op == OP_NONE) ? rd_addr : {cmd.va, cmd.el};
  assign b_addr = {cmd.vb, cmd.el};

  // divider state
  logic        div_run, div_neg, div_done, div_ovf;
  logic [63:0] dv_r, dv_b, dv_q;
  logic [63:0] dv_n;
  logic [6:0]  dv_cnt;
  logic [64:0] dv_try;
  logic        ovf;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    else if (h_vld) mem[h_addr] <= h;
    cur_q <= mem[a_addr];
    base_q <= mem[b_addr];
    cur_addr_q <= a_addr;
  end

  assign rd_data = cur_q;

  logic signed [63:0] mul_b;
  always_comb begin
    mul_b = (op_q == 3'(OP_UPD)) ? 64'(coef) : 64'(cur_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= 3'(OP_NONE);
      op_p <= 3'(OP_NONE);
      h_vld <= 1'b0;
    end else begin
      op_q <= (cmd.op == OP_DOT || cmd.op == OP_UPD) ? 3'(cmd.op) : 3'(OP_NONE);
      op_p <= op_q;
      h_vld <= (op_p == 3'(OP_UPD));
    end
    prod <= 64'(base_q) * mul_b;
    cur_p <= cur_q;
    cur_addr_p <= cur_addr_q;
    // floor(prod/2^16) is an arithmetic shift
    h <= sat32(64'(cur_p) - (prod >>> 16));
    h_addr <= cur_addr_p;
  end

  logic signed [63:0] hh;
  logic               hh_vld;
  always_ff @(posedge clk) begin
    if (rst) hh_vld <= 1'b0;
    else hh_vld <= h_vld;
    hh <= 64'(h) * 64'(h);
  end

  logic [63:0] mag;
  assign mag = acc[63] ? 64'(0) - acc : acc;
  assign dv_try = {dv_r, dv_n[63]} - {1'b0, dv_b};
  // integer quotient overflows when mag >= 2^15 * norm
  assign ovf = ({15'b0, mag} >= {norms[cmd.vb], 15'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      div_run <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      case (cmd.op)
        OP_CLR: acc <= '0;
        OP_DIV: if (!div_run && !div_done) begin
          div_run <= 1'b1;
          div_neg <= acc[63];
          div_ovf <= ovf;
          dv_b <= norms[cmd.vb];
          dv_n <= mag;
          dv_r <= '0;
          dv_q <= '0;
          dv_cnt <= 7'd80;
          // dot is held by the divider; start the norm sum afresh
          acc <= '0;
        end
        OP_NORM: norms[cmd.va] <= acc;
        default: ;
      endcase
      if (op_p == 3'(OP_DOT)) acc <= sat_add64(acc, prod);
      if (hh_vld) acc <= sat_add64(acc, hh);
      if (div_run) begin
        // restoring division of mag*2^16 by norm, one bit a cycle
        if (!dv_try[64]) begin
          dv_r <= dv_try[63:0];
          dv_q <= {dv_q[62:0], 1'b1};
        end else begin
          dv_r <= {dv_r[62:0], dv_n[63]};
          dv_q <= {dv_q[62:0], 1'b0};
        end
        dv_n <= {dv_n[62:0], 1'b0};
        dv_cnt <= dv_cnt - 7'd1;
        if (dv_cnt == 7'd1) begin
          div_run <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // quotient over 80 steps: mag*2^16/norm; saturate if >= 2^31
  logic [63:0] qf;
  assign qf = !dv_try[64] ? {dv_q[62:0], 1'b1} : {dv_q[62:0], 1'b0};
  always_ff @(posedge clk) begin
    if (div_run && dv_cnt == 7'd1) begin
      if (div_ovf || qf[63:31] != '0) coef <= div_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else coef <= div_neg ? -$signed(qf[31:0]) : $signed(qf[31:0]);
    end
  end

  assign sts.div_done = div_done;
  assign sts.acc_zero = (acc == '0);
  assign sts.busy = div_run | (op_q != 3'(OP_NONE)) | (op_p != 3'(OP_NONE)) |
                    h_vld | hh_vld;
endmodule
`default_nettype wire

@@ rtl/gso_controller.sv @@
// Controller: load counting, orthogonalisation sequence, output sequencing
`default_nettype none
module gso_controller import gso_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_idx,
  input  wire logic [3:0]    cfg_data,
  input  wire logic          in_fire,
  output logic               in_ready,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic               out_err,
  output logic               out_last,
  output logic [VW-1:0]      out_v,
  output logic [EW-1:0]      out_e,
  output cmd_t               cmd,
  input  wire sts_t          sts
);
  typedef enum logic [3:0] {
    S_LOAD, S_N0, S_N0W, S_CLR, S_DOT, S_DOTW, S_DIV, S_UPD, S_UPDW,
    S_CHK, S_RD, S_OUT, S_ERR
  } state_t;

  state_t state;
  logic [3:0] nv_reg, vl_reg, n, m;
  logic [VW-1:0] lv, v, j;
  logic [EW-1:0] le, e;
  logic [2:0] wait_cnt;

  assign n = clamp_reg(nv_reg, 4'(MaxVectors));
  assign m = clamp_reg(vl_reg, 4'(MaxLength));
  assign in_ready = (state == S_LOAD);
  assign wr_en = in_fire;
  assign wr_addr = {lv, le};
  assign rd_addr = {v, e};

  always_comb begin
    cmd = '{op: OP_NONE, va: v, vb: j, el: e};
    case (state)
      S_LOAD: cmd.op = OP_CLR;
      S_N0:  cmd.op = OP_DOT;
      S_N0W: cmd.op = OP_NORM;
      S_CLR: cmd.op = OP_CLR;
      S_DOT: cmd.op = OP_DOT;
      S_DIV: cmd.op = OP_DIV;
      S_UPD: cmd.op = OP_UPD;
      S_CHK: cmd.op = OP_NORM;
      default: ;
    endcase
    if (state == S_N0 || state == S_N0W) begin
      cmd.va = '0;
      cmd.vb = '0;
    end
  end

  logic last_e;
  assign last_e = (4'(e) == m - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      nv_reg <= 4'd8;
      vl_reg <= 4'd8;
      lv <= '0; le <= '0; v <= '0; j <= '0; e <= '0;
      out_valid <= 1'b0; out_err <= 1'b0; out_last <= 1'b0;
      wait_cnt <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CfgNumVectors) nv_reg <= cfg_data;
        else vl_reg <= cfg_data;
        lv <= '0; le <= '0;
      end
      case (state)
        S_LOAD: if (in_fire) begin
          if (4'(le) == m - 4'd1) begin
            le <= '0;
            if (4'(lv) == n - 4'd1) begin
              lv <= '0;
              e <= '0;
              state <= S_N0;
            end else lv <= lv + 1'b1;
          end else le <= le + 1'b1;
        end
        S_N0: begin
          // acc is held clear while loading
          if (last_e) begin
            e <= '0; wait_cnt <= '0; state <= S_N0W;
          end else e <= e + 1'b1;
        end
        S_N0W: if (!sts.busy) begin
          if (wait_cnt == 3'd1) begin
            if (sts.acc_zero) begin
              v <= '0; state <= S_ERR;
            end else if (n == 4'd1) begin
              v <= '0; e <= '0; state <= S_RD;
            end else begin
              v <= VW'(1); j <= '0; state <= S_CLR;
            end
          end else wait_cnt <= wait_cnt + 3'd1;
        end
        S_CLR: begin
          e <= '0; state <= S_DOT;
        end
        S_DOT: if (last_e) begin
          e <= '0; state <= S_DOTW;
        end else e <= e + 1'b1;
        S_DOTW: if (!sts.busy) state <= S_DIV;
        S_DIV: if (sts.div_done) state <= S_UPD;
        S_UPD: if (last_e) begin
          e <= '0; state <= S_UPDW;
        end else e <= e + 1'b1;
        S_UPDW: if (!sts.busy) begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (sts.acc_zero) state <= S_ERR;
          else if (j == v - 1'b1) begin
            if (4'(v) == n - 4'd1) begin
              v <= '0; e <= '0; state <= S_RD;
            end else begin
              v <= v + 1'b1; j <= '0; state <= S_CLR;
            end
          end else begin
            j <= j + 1'b1; state <= S_CLR;
          end
        end
        S_RD: begin
          // the memory read is registered along with out_valid
          out_valid <= 1'b1;
          out_err <= 1'b0;
          out_last <= (4'(v) == n - 4'd1) && last_e;
          out_v <= v; out_e <= e;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) state <= S_LOAD;
          else begin
            if (last_e) begin
              e <= '0; v <= v + 1'b1;
            end else e <= e + 1'b1;
            state <= S_RD;
          end
        end
        S_ERR: begin
          if (!out_valid) begin
            out_valid <= 1'b1; out_err <= 1'b1; out_last <= 1'b1;
            out_v <= v; out_e <= '0;
          end else if (out_ready) begin
            out_valid <= 1'b0; out_err <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/gram_schmidt_orthogonalizer.sv @@
// Top level of the Gram-Schmidt orthogonaliser
// Usage:
//  - in: one element_value beat per element, vector-major order; a set is
//    num_vectors * vector_length beats (registers clamp 0 to 1, above 8 to 8).
//  - cfg: write num_vectors (index 0) or vector_length (index 1) when idle;
//    any write restarts a partly loaded set.
//  - out: one beat per orthogonalised element, last on the final one, or a
//    single beat with dependent_error and last when a zero norm appears.
//  - After the last input beat: the norm of the first vector, then per
//    projection a dot pass, the serial divider and an update pass,
//    n(n-1)/2 projections; each output beat waits for its memory read,
//    so output beats never come back to back.
//  - Input is taken only while loading; no input beat is taken during
//    processing or output.
//  - Reset: registers return to 8, the load count clears; memory contents
//    are undefined until written.
//  - A stalled receiver holds the current result beat until taken.
`default_nettype none
module gram_schmidt_orthogonalizer import gso_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_idx,
  input  wire logic [3:0] cfg_data,
  gso_in_if.sink     in,
  gso_out_if.source  out
);
  cmd_t cmd;
  sts_t sts;
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [31:0] rd_data;
  logic in_ready, in_fire;
  logic [VW-1:0] ov;
  logic [EW-1:0] oe;
  logic oerr;

  assign in.ready = in_ready;
  assign in_fire = in.valid & in_ready;

  gso_controller u_ctrl (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_fire, .in_ready,
    .wr_en, .wr_addr, .rd_addr, .out_ready(out.ready), .out_valid(out.valid),
    .out_err(oerr), .out_last(out.last), .out_v(ov), .out_e(oe), .cmd, .sts
  );

  gso_datapath u_dp (
    .clk, .rst, .cmd, .wr_en, .wr_addr, .wr_data(in.element_value),
    .rd_addr, .rd_data, .sts
  );

  assign out.result_value = oerr ? 32'sd0 : rd_data;
  assign out.vector_number = 3'(ov);
  assign out.element_number = 3'(oe);
  assign out.dependent_error = oerr;
endmodule
`default_nettype wire

@@ rtl/gso_checker.sv @@
// Port-level checker for the orthogonaliser, bound to the top level
`default_nettype none
`include "gram_schmidt_orthogonalizer_macros.svh"
module gso_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_err,
  input wire logic out_last,
  input wire logic [2:0] out_e
);
  `GSO_ASSERT_IMPL(a_no_overlap, clk, rst, in_ready, !out_valid, "input taken during output")
  `GSO_ASSERT_IMPL(a_err_last, clk, rst, out_valid && out_err, out_last && out_e == 3'd0, "error beat malformed")
  `GSO_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_last), "stalled beat dropped")
  `GSO_ASSERT_NEXT(a_last_idle, clk, rst, out_valid && out_ready && out_last, !out_valid, "beat after last")
endmodule

bind gram_schmidt_orthogonalizer gso_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_err(out.dependent_error),
  .out_last(out.last), .out_e(out.element_number)
);
`default_nettype wire
